/* rtl/core/itclm_pkg.sv */
// ----------------------------------------------------------------------------
// itclm_pkg
// Shared types and constants of the two-core idle-time load monitor.
// ----------------------------------------------------------------------------
package itclm_pkg;

    localparam int TIME_WIDTH  = 48;
    localparam int LOAD_W      = 14;
    localparam int LOAD_BITS   = 14;
    localparam int BIT_W       = $clog2(LOAD_BITS);
    localparam int GAP_W       = 16;
    localparam int PERIOD_W    = 32;
    localparam int WARM_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = ((TIME_WIDTH + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = ((2 * LOAD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 3;

    localparam logic [LOAD_W-1:0] FULL_LOAD = LOAD_W'(10000);

    localparam logic [GAP_W-1:0]    RST_GAP_LIMIT = GAP_W'(1000);
    localparam logic [PERIOD_W-1:0] RST_PERIOD    = PERIOD_W'(2000000);
    localparam logic [WARM_W-1:0]   RST_WARMUP    = WARM_W'(2);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ACT_HOOK    = 2'd0,
        ACT_MEASURE = 2'd1,
        ACT_START   = 2'd2,
        ACT_STOP    = 2'd3
    } t_action;

    typedef struct packed {
        logic accept;
        logic init;
        logic dbl;
        logic add;
        logic store;
        logic core;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_stat;

    typedef struct packed {
        logic              closed;
        logic              on;
        logic              valid;
        logic [LOAD_W-1:0] load1;
        logic [LOAD_W-1:0] load0;
    } t_result;

endpackage

/* rtl/core/itclm_ctrl.sv */
// ----------------------------------------------------------------------------
// itclm_ctrl
// Sequencer: takes items, steps the scaled-quotient unit bit by bit for each
// core, and hands each finished result to the output buffer.
// ----------------------------------------------------------------------------
module itclm_ctrl
    import itclm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_full,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    output logic     o_push
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_DBL   = 6'b000100,
        S_ADD   = 6'b001000,
        S_STORE = 6'b010000,
        S_PUSH  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_core, n_core;

    assign o_in_ready = (r_state == S_IDLE) && !i_full;

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_core  = r_core;
        o_cmd   = '0;
        o_push  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_core       = 1'b0;
                    n_state      = i_stat.need_div ? S_INIT : S_PUSH;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                o_cmd.core = r_core;
                n_bit      = BIT_W'(LOAD_BITS - 1);
                n_state    = S_DBL;
            end
            S_DBL: begin
                o_cmd.dbl = 1'b1;
                // add step only where the scale constant has a one
                if (FULL_LOAD[r_bit]) begin
                    n_state = S_ADD;
                end else if (r_bit == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_bit == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_DBL;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                o_cmd.core  = r_core;
                if (!r_core) begin
                    n_core  = 1'b1;
                    n_state = S_INIT;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_push  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_core  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_core  <= n_core;
        end
    end

endmodule

/* rtl/core/itclm_datapath.sv */
// ----------------------------------------------------------------------------
// itclm_datapath
// Monitor state, configuration registers and the serial scaled-quotient
// unit (one doubling or one add step per cycle, modulo the elapsed time).
// ----------------------------------------------------------------------------
module itclm_datapath
    import itclm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_action               i_action,
    input  logic                  i_core,
    input  logic [TIME_WIDTH-1:0] i_time,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_result               o_result
);

    localparam int TW = TIME_WIDTH;

    // configuration
    logic [GAP_W-1:0]    r_gap_lim;
    logic [PERIOD_W-1:0] r_period;
    logic [WARM_W-1:0]   r_warm_per;

    // monitor state
    logic              r_enabled, n_enabled;
    logic [WARM_W-1:0] r_warm, n_warm;
    logic [TW-1:0]     r_acc[2], n_acc[2];
    logic [TW-1:0]     r_hook[2], n_hook[2];
    logic [TW-1:0]     r_snap[2], n_snap[2];
    logic [TW-1:0]     r_meas, n_meas;
    logic [LOAD_W-1:0] r_load[2], n_load[2];
    logic              r_valid, n_valid;
    logic              r_closed, n_closed;

    // quotient unit
    logic [TW-1:0]     r_d[2], n_d[2];
    logic [TW-1:0]     r_e, n_e;
    logic [TW-1:0]     r_ed, n_ed;
    logic [TW-1:0]     r_dcur, n_dcur;
    logic [TW-1:0]     r_rem, n_rem;
    logic [LOAD_W-1:0] r_q, n_q;
    logic              r_ge, n_ge;

    logic [TW-1:0] w_gap;
    logic [TW-1:0] w_elapsed;
    logic          w_period_hit;
    logic          w_warm_skip;
    logic          w_start;
    logic [TW:0]   w_dbl;
    logic [TW:0]   w_dbl_sub;

    assign w_gap        = i_time - r_hook[i_core];
    assign w_elapsed    = i_time - r_meas;
    assign w_period_hit = w_elapsed >= TW'(r_period);
    assign w_warm_skip  = r_warm < r_warm_per;
    assign w_start      = i_cmd.accept && !r_enabled
                       && (i_action == ACT_MEASURE || i_action == ACT_START);
    assign w_dbl        = {r_rem, 1'b0};
    assign w_dbl_sub    = w_dbl - {1'b0, r_e};

    assign o_stat.need_div = (i_action == ACT_MEASURE) && r_enabled && w_period_hit
                          && !w_warm_skip && (w_elapsed != '0);

    always_comb begin
        n_enabled = r_enabled;
        n_warm    = r_warm;
        n_acc     = r_acc;
        n_hook    = r_hook;
        n_snap    = r_snap;
        n_meas    = r_meas;
        n_load    = r_load;
        n_valid   = r_valid;
        n_closed  = r_closed;
        n_d       = r_d;
        n_e       = r_e;
        n_ed      = r_ed;
        n_dcur    = r_dcur;
        n_rem     = r_rem;
        n_q       = r_q;
        n_ge      = r_ge;

        if (i_cmd.accept) begin
            n_closed = 1'b0;
            unique case (i_action)
                ACT_HOOK: begin
                    if (r_enabled) begin
                        // a stored zero stands for no earlier hook
                        if (r_hook[i_core] != '0 && w_gap < TW'(r_gap_lim)) begin
                            n_acc[i_core] = r_acc[i_core] + w_gap;
                        end
                        n_hook[i_core] = i_time;
                    end
                end
                ACT_MEASURE: begin
                    if (r_enabled && w_period_hit) begin
                        n_d[0]   = r_acc[0] - r_snap[0];
                        n_d[1]   = r_acc[1] - r_snap[1];
                        n_e      = w_elapsed;
                        n_snap   = r_acc;
                        n_meas   = i_time;
                        n_closed = 1'b1;
                        if (w_warm_skip) begin
                            n_warm  = r_warm + 1'b1;
                            n_valid = 1'b0;
                            n_load  = '{default: '0};
                        end
                    end
                end
                ACT_START: begin
                end
                ACT_STOP: begin
                    if (r_enabled) begin
                        n_enabled = 1'b0;
                        n_valid   = 1'b0;
                        n_load    = '{default: '0};
                    end
                end
                default: begin
                end
            endcase
            if (w_start) begin
                n_enabled = 1'b1;
                n_warm    = '0;
                n_acc     = '{default: '0};
                n_hook    = '{default: '0};
                n_snap    = '{default: '0};
                n_load    = '{default: '0};
                n_meas    = i_time;
                n_valid   = 1'b0;
            end
        end

        if (i_cmd.init) begin
            n_rem  = '0;
            n_q    = '0;
            n_dcur = r_d[i_cmd.core];
            n_ed   = r_e - r_d[i_cmd.core];
            n_ge   = r_d[i_cmd.core] >= r_e;
        end

        // rem <- 2*rem mod e
        if (i_cmd.dbl) begin
            if (!w_dbl_sub[TW]) begin
                n_rem = w_dbl_sub[TW-1:0];
                n_q   = {r_q[LOAD_W-2:0], 1'b1};
            end else begin
                n_rem = w_dbl[TW-1:0];
                n_q   = {r_q[LOAD_W-2:0], 1'b0};
            end
        end

        // rem <- rem + d mod e
        if (i_cmd.add) begin
            if (r_rem >= r_ed) begin
                n_rem = r_rem - r_ed;
                n_q   = r_q + LOAD_W'(1);
            end else begin
                n_rem = r_rem + r_dcur;
            end
        end

        if (i_cmd.store) begin
            n_load[i_cmd.core] = r_ge ? '0 : FULL_LOAD - r_q;
            if (i_cmd.core) begin
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_lim  <= RST_GAP_LIMIT;
            r_period   <= RST_PERIOD;
            r_warm_per <= RST_WARMUP;
            r_enabled  <= 1'b0;
            r_warm     <= '0;
            r_acc      <= '{default: '0};
            r_hook     <= '{default: '0};
            r_snap     <= '{default: '0};
            r_meas     <= '0;
            r_load     <= '{default: '0};
            r_valid    <= 1'b0;
            r_closed   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAP_LIMIT: r_gap_lim  <= i_cfg_data[GAP_W-1:0];
                    CFG_PERIOD:    r_period   <= i_cfg_data[PERIOD_W-1:0];
                    CFG_WARMUP:    r_warm_per <= i_cfg_data[WARM_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_enabled <= n_enabled;
            r_warm    <= n_warm;
            r_acc     <= n_acc;
            r_hook    <= n_hook;
            r_snap    <= n_snap;
            r_meas    <= n_meas;
            r_load    <= n_load;
            r_valid   <= n_valid;
            r_closed  <= n_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_e    <= n_e;
        r_ed   <= n_ed;
        r_dcur <= n_dcur;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_ge   <= n_ge;
    end

    assign o_result.closed = r_closed;
    assign o_result.on     = r_enabled;
    assign o_result.valid  = r_valid;
    assign o_result.load0  = r_valid ? r_load[0] : '0;
    assign o_result.load1  = r_valid ? r_load[1] : '0;

endmodule

/* rtl/core/itclm_obuf.sv */
// ----------------------------------------------------------------------------
// itclm_obuf
// Two-entry result buffer: output register plus one waiting entry, so a new
// item can be taken while a result is still held by the sink.
// ----------------------------------------------------------------------------
module itclm_obuf
    import itclm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_full,
    output t_result o_data
);

    logic [1:0] r_cnt, n_cnt;
    t_result    r_q0, r_q1;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_data  = r_q0;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_pop))) begin
            r_q0 <= i_data;
        end else if (w_pop && r_cnt == 2'd2) begin
            r_q0 <= r_q1;
        end
        if (i_push && r_cnt == 2'd1 && !w_pop) begin
            r_q1 <= i_data;
        end
    end

endmodule

/* rtl/core/idle_time_cpu_load_monitor_top.sv */
// ----------------------------------------------------------------------------
// idle_time_cpu_load_monitor_top
// Two-core idle-time load monitor: idle hooks accumulate idle gaps, measure
// events turn idle deltas into load in hundredths of a percent.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    tdata: time_us; tuser: action, core
//  m_axis   out  m_axis_tvalid/m_axis_tready    tdata: loads; tuser: flags
//  cfg      in   i_cfg_we                       i_cfg_idx, i_cfg_data
//
// hook, start, stop and measure events that do not compute go from accept straight to the push.
// a measure that computes loads first runs the serial quotient unit:
// 14 doubling and 5 add steps plus setup and store for each core.
// reset is synchronous; no clearing pass, the block is ready right after it.
// a result waiting at m_axis does not block the next item; a second
// unaccepted result stalls s_axis.
// ----------------------------------------------------------------------------
module idle_time_cpu_load_monitor_top
    import itclm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // time_us
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // action[1:0], core
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // load_core0, load_core1, zero pad
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // load_valid, monitor_on, period_closed
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_result  w_result;
    t_result  w_out;
    logic     w_push;
    logic     w_full;

    itclm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_full     (w_full),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .o_push     (w_push)
    );

    itclm_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_action   (t_action'(s_axis_tuser[1:0])),
        .i_core     (s_axis_tuser[2]),
        .i_time     (s_axis_tdata[TIME_WIDTH-1:0]),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_result   (w_result)
    );

    itclm_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_full  (w_full),
        .o_data  (w_out)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_out.load1, w_out.load0});
    assign m_axis_tuser = {w_out.closed, w_out.on, w_out.valid};

endmodule

/* rtl/core/itclm_checker.sv */
// ----------------------------------------------------------------------------
// itclm_checker
// Port-level checks of the load monitor, bound to the top level.
// ----------------------------------------------------------------------------
module itclm_checker
    import itclm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // a valid measurement only exists while monitoring is on
    a_valid_needs_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("load_valid without monitor_on");

    // no valid measurement means both loads read zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[2*LOAD_W-1:0] == '0)
        else $error("loads nonzero while not valid");

    // a closed period only happens while monitoring is on
    a_closed_needs_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
        else $error("period_closed while monitor off");

    // one item at a time: input stalls right after an item is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind idle_time_cpu_load_monitor_top itclm_checker u_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives hook, measure, start and stop events into the two-core load monitor
// over the stream input and tracks idle sums, warm-up and load math on the
// side, so every result item is checked field by field against its own
// prediction. Runs through several register settings with random stalls.
// ----------------------------------------------------------------------------
module testbench
    import itclm_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_ITEMS = 205;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    // ------------------------------------------------------------------------
    // load tracker: mirrors the monitor state and holds expected result items
    // ------------------------------------------------------------------------
    class cpu_load_tracker;
        logic [GAP_W-1:0]      gap_limit;
        logic [PERIOD_W-1:0]   period;
        logic [WARM_W-1:0]     warmup_len;
        logic                  on;
        logic [WARM_W-1:0]     warm_seen;
        logic [TIME_WIDTH-1:0] idle_sum [2];
        logic [TIME_WIDTH-1:0] last_hook [2];
        logic [TIME_WIDTH-1:0] idle_mark [2];
        logic [TIME_WIDTH-1:0] measure_mark;
        logic [LOAD_W-1:0]     load [2];
        logic                  loads_valid;
        t_result               expected_loads [$];
        int                    errors;
        int                    checked;

        function new();
            gap_limit    = RST_GAP_LIMIT;
            period       = RST_PERIOD;
            warmup_len   = RST_WARMUP;
            on           = 1'b0;
            warm_seen    = '0;
            idle_sum     = '{'0, '0};
            last_hook    = '{'0, '0};
            idle_mark    = '{'0, '0};
            measure_mark = '0;
            load         = '{'0, '0};
            loads_valid  = 1'b0;
            errors       = 0;
            checked      = 0;
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_GAP_LIMIT: gap_limit  = value[GAP_W-1:0];
                CFG_PERIOD:    period     = value[PERIOD_W-1:0];
                CFG_WARMUP:    warmup_len = value[WARM_W-1:0];
                default: ;
            endcase
        endfunction

        function void restart(logic [TIME_WIDTH-1:0] now);
            on           = 1'b1;
            warm_seen    = '0;
            idle_sum     = '{'0, '0};
            last_hook    = '{'0, '0};
            idle_mark    = '{'0, '0};
            load         = '{'0, '0};
            measure_mark = now;
            loads_valid  = 1'b0;
        endfunction

        // 10000 - floor(idle * 10000 / span), zero once idle covers the span
        function logic [LOAD_W-1:0] load_for(logic [TIME_WIDTH-1:0] idle,
                                             logic [TIME_WIDTH-1:0] span);
            logic [63:0] frac;
            if (idle >= span) return '0;
            frac = (64'(idle) * 64'd10000) / 64'(span);
            return LOAD_W'(64'd10000 - frac);
        endfunction

        function void predict_event(t_action act, logic core, logic [TIME_WIDTH-1:0] now);
            logic [TIME_WIDTH-1:0] gap;
            logic [TIME_WIDTH-1:0] elapsed;
            logic [TIME_WIDTH-1:0] d0;
            logic [TIME_WIDTH-1:0] d1;
            logic                  closed;
            t_result               res;
            closed = 1'b0;
            case (act)
                ACT_HOOK: begin
                    if (on) begin
                        // a stored zero stamp reads as no previous hook
                        if (last_hook[core] != '0) begin
                            gap = now - last_hook[core];
                            if (gap < TIME_WIDTH'(gap_limit))
                                idle_sum[core] = idle_sum[core] + gap;
                        end
                        last_hook[core] = now;
                    end
                end
                ACT_MEASURE: begin
                    if (!on) begin
                        restart(now);
                    end else begin
                        elapsed = now - measure_mark;
                        if (elapsed >= TIME_WIDTH'(period)) begin
                            d0           = idle_sum[0] - idle_mark[0];
                            d1           = idle_sum[1] - idle_mark[1];
                            idle_mark[0] = idle_sum[0];
                            idle_mark[1] = idle_sum[1];
                            measure_mark = now;
                            closed       = 1'b1;
                            if (warm_seen < warmup_len) begin
                                warm_seen   = warm_seen + 1'b1;
                                loads_valid = 1'b0;
                                load        = '{'0, '0};
                            end else if (elapsed != '0) begin
                                load[0]     = load_for(d0, elapsed);
                                load[1]     = load_for(d1, elapsed);
                                loads_valid = 1'b1;
                            end
                        end
                    end
                end
                ACT_START: begin
                    if (!on) restart(now);
                end
                default: begin
                    if (on) begin
                        on          = 1'b0;
                        loads_valid = 1'b0;
                        load        = '{'0, '0};
                    end
                end
            endcase
            res.load0  = loads_valid ? load[0] : '0;
            res.load1  = loads_valid ? load[1] : '0;
            res.valid  = loads_valid;
            res.on     = on;
            res.closed = closed;
            expected_loads.push_back(res);
        endfunction

        function int pending();
            return expected_loads.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) $display("mismatch at result %0d: %s", checked, what);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] flags);
            t_result want;
            if (expected_loads.size() == 0) begin
                report($sformatf("unexpected item, tdata %h tuser %b", data, flags));
            end else begin
                want = expected_loads.pop_front();
                if (data[LOAD_W-1:0] !== want.load0)
                    report($sformatf("load_core0 %0d, want %0d", data[LOAD_W-1:0], want.load0));
                if (data[2*LOAD_W-1:LOAD_W] !== want.load1)
                    report($sformatf("load_core1 %0d, want %0d",
                                     data[2*LOAD_W-1:LOAD_W], want.load1));
                if (flags[0] !== want.valid)
                    report($sformatf("load_valid %b, want %b", flags[0], want.valid));
                if (flags[1] !== want.on)
                    report($sformatf("monitor_on %b, want %b", flags[1], want.on));
                if (flags[2] !== want.closed)
                    report($sformatf("period_closed %b, want %b", flags[2], want.closed));
            end
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // dut
    // ------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // time_us
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // action[1:0], core
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // load_core0, load_core1, zero pad
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // load_valid, monitor_on, period_closed
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    idle_time_cpu_load_monitor_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    cpu_load_tracker       cpu_load = new();
    logic [TIME_WIDTH-1:0] t_now;
    int unsigned           cur_gap;
    logic [PERIOD_W-1:0]   cur_period;
    logic                  send_burst;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    task automatic drive_event(input t_action act, input logic core,
                               input logic [TIME_WIDTH-1:0] stamp);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(stamp);
        s_axis_tuser  <= {core, act};
        do @(posedge i_clk); while (!s_axis_tready);
        cpu_load.predict_event(act, core, stamp);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (cpu_load.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        cpu_load.write_config(idx, value);
    endtask

    task automatic program_phase(input int unsigned gap_lim, input logic [PERIOD_W-1:0] per,
                                 input int unsigned warm);
        write_register(CFG_GAP_LIMIT, CFG_DATA_W'(gap_lim));
        write_register(CFG_PERIOD, CFG_DATA_W'(per));
        write_register(CFG_WARMUP, CFG_DATA_W'(warm));
        i_cfg_we   <= 1'b0;
        cur_gap    = gap_lim;
        cur_period = per;
    endtask

    // mostly hook/measure traffic on a moving clock, with some start/stop and noise
    task automatic random_event();
        int                    pick;
        int                    how;
        logic                  core;
        logic [TIME_WIDTH-1:0] target;
        pick = $urandom_range(0, 99);
        core = 1'($urandom_range(0, 1));
        if (pick < 3) begin
            drive_event(t_action'($urandom_range(0, 3)), core,
                        TIME_WIDTH'({$urandom, $urandom}));
        end else if (pick < 70) begin
            if ($urandom_range(0, 9) == 0)
                t_now = t_now + TIME_WIDTH'($urandom_range(cur_gap, 2 * cur_gap + 2));
            else
                t_now = t_now + TIME_WIDTH'($urandom_range(0, cur_gap / 2 + 1));
            drive_event(ACT_HOOK, core, t_now);
        end else if (pick < 90) begin
            how    = $urandom_range(0, 3);
            target = cpu_load.measure_mark + TIME_WIDTH'(cur_period);
            case (how)
                0: target = target - 1'b1;
                2: target = target + TIME_WIDTH'($urandom_range(1, 50));
                default: ;
            endcase
            if (how == 3)
                t_now = t_now + TIME_WIDTH'($urandom_range(0, 20));
            else if (target - t_now < {1'b0, {(TIME_WIDTH-1){1'b1}}})
                t_now = target;
            drive_event(ACT_MEASURE, core, t_now);
        end else if (pick < 95) begin
            t_now = t_now + TIME_WIDTH'($urandom_range(0, 30));
            drive_event(ACT_START, core, t_now);
        end else begin
            t_now = t_now + TIME_WIDTH'($urandom_range(0, 30));
            drive_event(ACT_STOP, core, t_now);
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int seen;
        seen          = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (seen == 400)
                stall = 400;    // long hold-off, lets the block back up its input
            else if ((seen / 150) % 2 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            cpu_load.check_result(m_axis_tdata, m_axis_tuser);
            seen++;
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned         gap_lim;
        logic [PERIOD_W-1:0] per;
        int unsigned         warm;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        send_burst    = 1'b0;
        t_now         = '0;
        cur_gap       = RST_GAP_LIMIT;
        cur_period    = RST_PERIOD;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part on reset register values
        drive_event(ACT_HOOK, 1'b0, 48'd100);           // hook while off
        drive_event(ACT_STOP, 1'b0, 48'd200);           // stop while off
        drive_event(ACT_MEASURE, 1'b1, 48'd1000);       // measure while off starts
        drive_event(ACT_START, 1'b0, 48'd5000);         // start while on
        drive_event(ACT_HOOK, 1'b0, 48'd0);             // hook at stamp zero
        drive_event(ACT_HOOK, 1'b0, 48'd500);
        drive_event(ACT_HOOK, 1'b0, 48'd900);
        drive_event(ACT_HOOK, 1'b1, 48'd1000);
        drive_event(ACT_HOOK, 1'b1, 48'd1999);          // just under the gap limit
        drive_event(ACT_HOOK, 1'b1, 48'd2999);          // right at the gap limit
        drive_event(ACT_HOOK, 1'b1, 48'd2000);          // time going backwards
        drive_event(ACT_MEASURE, 1'b0, 48'd5000);       // period not yet over
        drive_event(ACT_MEASURE, 1'b0, 48'd2001000);    // warm-up
        drive_event(ACT_MEASURE, 1'b0, 48'd4001000);    // warm-up
        drive_event(ACT_HOOK, 1'b0, 48'd4001100);
        drive_event(ACT_HOOK, 1'b0, 48'd4002099);
        drive_event(ACT_HOOK, 1'b1, 48'd4001500);
        drive_event(ACT_HOOK, 1'b1, 48'd4002400);
        drive_event(ACT_MEASURE, 1'b1, 48'd6001000);    // first valid loads
        drive_event(ACT_HOOK, 1'b0, TIME_MAX);
        drive_event(ACT_HOOK, 1'b0, 48'd5);             // gap across the wrap
        drive_event(ACT_MEASURE, 1'b0, 48'd10);         // elapsed wraps around
        drive_event(ACT_STOP, 1'b1, 48'd20);
        drive_event(ACT_START, 1'b1, TIME_MAX);
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin gap_lim = 1000;  per = 32'd2000;     warm = 2;  end
                1: begin gap_lim = 1;     per = 32'd1;        warm = 0;  end
                2: begin gap_lim = 65535; per = 32'hFFFFFFFF; warm = 15; end
                3: begin gap_lim = 300;   per = 32'd500;      warm = 1;  end
                4: begin gap_lim = 5000;  per = 32'd20000;    warm = 0;  end
                5: begin gap_lim = 2000;  per = 32'd3000;     warm = 3;  end
                default: begin
                    gap_lim = $urandom_range(1, 4000);
                    per     = PERIOD_W'($urandom_range(50, 20000));
                    warm    = $urandom_range(0, 15);
                end
            endcase
            program_phase(gap_lim, per, warm);
            // one phase runs across the end of the time range
            if (ph == 5)
                t_now = TIME_MAX - 48'd30000;
            else if (ph % 2 == 0)
                t_now = TIME_WIDTH'({$urandom, $urandom});
            else
                t_now = TIME_WIDTH'($urandom_range(1, 100000));
            send_burst = (ph == 3 || ph == 6);
            for (int n = 0; n < PHASE_ITEMS; n++) random_event();
            // sender waits for every outstanding result before the next setting
            drain_results();
        end

        repeat (60) @(negedge i_clk);
        if (cpu_load.errors == 0 && cpu_load.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
